>>> sv/tchb_pkg.sv
// Shared constants, types and codes for the touch contact history buffer.
package tchb_pkg;

	localparam int CONTACTS   = 10;
	localparam int RING_DEPTH = 32;
	localparam int READ_COUNT = 16;

	localparam int CID_W  = (CONTACTS > 1) ? $clog2(CONTACTS) : 1;
	localparam int RI_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int CNT_W  = $clog2(READ_COUNT + 1);
	localparam int K_W    = (READ_COUNT > 1) ? $clog2(READ_COUNT) : 1;
	localparam int AW     = $clog2(CONTACTS * RING_DEPTH);
	localparam int RD_OFF = READ_COUNT % RING_DEPTH;

	localparam int OQ_DEPTH = 3;
	localparam int OQ_PW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	localparam int FRAME_W = 8;

	localparam logic [1:0] OP_PRESS   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	localparam logic [1:0] ST_RELEASE = 2'd0;
	localparam logic [1:0] ST_ENTER   = 2'd1;
	localparam logic [1:0] ST_MOVE    = 2'd2;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [1:0]         status;
		logic [31:0]        x;
		logic [31:0]        y;
		logic [15:0]        pressure;
		logic [15:0]        minor;
		logic [15:0]        major;
	} hist_entry_t;

	typedef struct packed {
		hist_entry_t entry;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic do_press;
		logic do_release;
		logic read_start;
		logic read_issue;
	} tchb_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       id_ok;
		logic       slot_ok;
		logic       credit;
		logic       read_last;
	} tchb_sts_t;

endpackage

>>> sv/tchb_ctrl.sv
// Control sequencer: takes an item, runs the update or the history read.
module tchb_ctrl
	import tchb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  tchb_sts_t sts,
	output tchb_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n    = S_EXEC;
				end
			end
			S_EXEC: begin
				state_n = S_IDLE;
				case (sts.op)
					OP_PRESS:   cmd.do_press   = sts.id_ok;
					OP_RELEASE: cmd.do_release = sts.id_ok;
					OP_READ: begin
						if (sts.slot_ok) begin
							cmd.read_start = 1'b1;
							state_n        = S_READ;
						end
					end
					default: ;
				endcase
			end
			S_READ: begin
				if (sts.credit) begin
					cmd.read_issue = 1'b1;
					if (sts.read_last)
						state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

endmodule

>>> sv/tchb_dp.sv
// Datapath: item latch, per-contact state, slot tables, history ring and output queue.
module tchb_dp
	import tchb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tchb_cmd_t   cmd,
	output tchb_sts_t   sts,
	input  logic [1:0]  opcode,
	input  logic [7:0]  contact_id,
	input  logic [3:0]  read_slot,
	input  logic [31:0] x_coord,
	input  logic [31:0] y_coord,
	input  logic [15:0] pressure,
	input  logic [15:0] touch_minor,
	input  logic [15:0] touch_major,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item
);

	// latched item
	logic [1:0]  op_q;
	logic [7:0]  cid_q;
	logic [3:0]  slot_q;
	logic [31:0] x_q;
	logic [31:0] y_q;
	logic [15:0] pres_q;
	logic [15:0] minor_q;
	logic [15:0] major_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= opcode;
			cid_q   <= contact_id;
			slot_q  <= read_slot;
			x_q     <= x_coord;
			y_q     <= y_coord;
			pres_q  <= pressure;
			minor_q <= touch_minor;
			major_q <= touch_major;
		end
	end

	// per-contact state
	logic [RI_W-1:0]    wp_q    [CONTACTS];
	logic [CNT_W-1:0]   cnt_q   [CONTACTS];
	logic [FILL_W-1:0]  fill_q  [CONTACTS];
	logic [FRAME_W-1:0] frame_q [CONTACTS];
	logic [1:0]         pst_q   [CONTACTS];

	// slot tables
	logic [CID_W-1:0] owner_q  [CONTACTS];
	logic             owner_v_q[CONTACTS];
	logic [CID_W-1:0] prev_q   [CONTACTS];
	logic             prev_v_q [CONTACTS];
	logic [CID_W-1:0] owner_n  [CONTACTS];
	logic             owner_v_n[CONTACTS];
	logic [CID_W-1:0] prev_n   [CONTACTS];
	logic             prev_v_n [CONTACTS];

	logic [CID_W-1:0] slot_i;
	logic [CID_W-1:0] res_c;
	logic [CID_W-1:0] sel_c;
	logic             upd;
	logic [1:0]       st_new;
	hist_entry_t      wr_entry;
	logic [AW-1:0]    wr_addr;
	logic [RI_W:0]    rp_sum;
	logic [RI_W-1:0]  rp_start;

	assign slot_i = slot_q[CID_W-1:0];
	assign upd    = cmd.do_press | cmd.do_release;

	// a read goes to the owner, else the previous owner, else the slot itself
	always_comb begin
		if (owner_v_q[slot_i])
			res_c = owner_q[slot_i];
		else if (prev_v_q[slot_i])
			res_c = prev_q[slot_i];
		else
			res_c = slot_i;
	end

	assign sel_c = (op_q == OP_READ) ? res_c : cid_q[CID_W-1:0];

	assign sts.op      = op_q;
	assign sts.id_ok   = ({24'd0, cid_q} < CONTACTS);
	assign sts.slot_ok = ({28'd0, slot_q} < CONTACTS);

	always_comb begin
		if (cmd.do_release)
			st_new = ST_RELEASE;
		else if (pst_q[sel_c] == ST_RELEASE)
			st_new = ST_ENTER;
		else
			st_new = ST_MOVE;

		wr_entry.frame  = frame_q[sel_c];
		wr_entry.status = st_new;
		if (cmd.do_release) begin
			wr_entry.x        = '1;
			wr_entry.y        = '1;
			wr_entry.pressure = '0;
			wr_entry.minor    = '0;
			wr_entry.major    = '0;
		end else begin
			wr_entry.x        = x_q;
			wr_entry.y        = y_q;
			wr_entry.pressure = pres_q;
			wr_entry.minor    = minor_q;
			wr_entry.major    = major_q;
		end
	end

	assign wr_addr = AW'(sel_c) * AW'(RING_DEPTH) + AW'(wp_q[sel_c]);

	// slot table update
	always_comb begin
		logic found;
		logic done;
		found = 1'b0;
		done  = 1'b0;
		for (int i = 0; i < CONTACTS; i++) begin
			owner_n[i]   = owner_q[i];
			owner_v_n[i] = owner_v_q[i];
			prev_n[i]    = prev_q[i];
			prev_v_n[i]  = prev_v_q[i];
			if (owner_v_q[i] && owner_q[i] == sel_c)
				found = 1'b1;
		end
		if (cmd.do_press && st_new == ST_ENTER && !found) begin
			for (int i = 0; i < CONTACTS; i++) begin
				if (!done && !owner_v_q[i]) begin
					owner_n[i]   = sel_c;
					owner_v_n[i] = 1'b1;
					done         = 1'b1;
				end
			end
		end
		if (cmd.do_release) begin
			for (int i = 0; i < CONTACTS; i++) begin
				if (!done && owner_v_q[i] && owner_q[i] == sel_c) begin
					prev_n[i]    = sel_c;
					prev_v_n[i]  = 1'b1;
					owner_v_n[i] = 1'b0;
					done         = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CONTACTS; i++) begin
				wp_q[i]      <= '0;
				cnt_q[i]     <= '0;
				fill_q[i]    <= '0;
				frame_q[i]   <= '0;
				pst_q[i]     <= ST_RELEASE;
				owner_q[i]   <= '0;
				owner_v_q[i] <= 1'b0;
				prev_q[i]    <= '0;
				prev_v_q[i]  <= 1'b0;
			end
		end else if (upd) begin
			wp_q[sel_c] <= (wp_q[sel_c] == RI_W'(RING_DEPTH - 1)) ? '0 : wp_q[sel_c] + 1'b1;
			if (cnt_q[sel_c] != CNT_W'(READ_COUNT))
				cnt_q[sel_c] <= cnt_q[sel_c] + 1'b1;
			if (fill_q[sel_c] != FILL_W'(RING_DEPTH))
				fill_q[sel_c] <= fill_q[sel_c] + 1'b1;
			frame_q[sel_c] <= frame_q[sel_c] + 1'b1;
			pst_q[sel_c]   <= st_new;
			for (int i = 0; i < CONTACTS; i++) begin
				owner_q[i]   <= owner_n[i];
				owner_v_q[i] <= owner_v_n[i];
				prev_q[i]    <= prev_n[i];
				prev_v_q[i]  <= prev_v_n[i];
			end
		end
	end

	// read walker
	logic [CID_W-1:0]  rd_c_q;
	logic [RI_W-1:0]   rd_rp_q;
	logic [K_W-1:0]    rd_k_q;
	logic [FILL_W-1:0] rd_fill_q;
	logic [AW-1:0]     rd_addr;

	// newest window start once the count reaches READ_COUNT, wrapped once; else zero
	always_comb begin
		rp_sum = (RI_W + 1)'(wp_q[sel_c]) + (RI_W + 1)'(RING_DEPTH - RD_OFF);
		if (rp_sum >= (RI_W + 1)'(RING_DEPTH))
			rp_sum = rp_sum - (RI_W + 1)'(RING_DEPTH);
		rp_start = (cnt_q[sel_c] == CNT_W'(READ_COUNT)) ? rp_sum[RI_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_k_q <= '0;
		end else if (cmd.read_start) begin
			rd_k_q <= '0;
		end else if (cmd.read_issue) begin
			rd_k_q <= rd_k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_start) begin
			rd_c_q    <= sel_c;
			rd_rp_q   <= rp_start;
			rd_fill_q <= fill_q[sel_c];
		end else if (cmd.read_issue) begin
			rd_rp_q <= (rd_rp_q == RI_W'(RING_DEPTH - 1)) ? '0 : rd_rp_q + 1'b1;
		end
	end

	assign rd_addr       = AW'(rd_c_q) * AW'(RING_DEPTH) + AW'(rd_rp_q);
	assign sts.read_last = (rd_k_q == K_W'(READ_COUNT - 1));

	// history ring; unwritten entries are masked by the fill count
	hist_entry_t ring_mem [CONTACTS * RING_DEPTH];
	hist_entry_t rd_data_s1;
	logic        rd_ok_s1;
	logic        rd_last_s1;
	logic        inflight_s1;

	always_ff @(posedge clk) begin
		if (upd)
			ring_mem[wr_addr] <= wr_entry;
		if (cmd.read_issue) begin
			rd_data_s1 <= ring_mem[rd_addr];
			rd_ok_s1   <= (FILL_W'(rd_rp_q) < rd_fill_q);
			rd_last_s1 <= sts.read_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_s1 <= 1'b0;
		else
			inflight_s1 <= cmd.read_issue;
	end

	// output queue
	out_item_t        oq_mem [OQ_DEPTH];
	logic [OQ_PW-1:0] oq_head_q;
	logic [OQ_PW-1:0] oq_tail_q;
	logic [OQ_CW-1:0] oq_cnt_q;
	logic             oq_push;
	logic             oq_pop;
	out_item_t        push_item;

	assign oq_push = inflight_s1;
	assign oq_pop  = out_valid && !out_stall;

	always_comb begin
		push_item.entry = rd_ok_s1 ? rd_data_s1 : '0;
		push_item.last  = rd_last_s1;
	end

	assign sts.credit = ((OQ_CW + 1)'(oq_cnt_q) + (OQ_CW + 1)'(inflight_s1))
	                    <= (OQ_CW + 1)'(OQ_DEPTH - 1);

	always_ff @(posedge clk) begin
		if (oq_push)
			oq_mem[oq_tail_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_head_q <= '0;
			oq_tail_q <= '0;
			oq_cnt_q  <= '0;
		end else begin
			if (oq_push)
				oq_tail_q <= (oq_tail_q == OQ_PW'(OQ_DEPTH - 1)) ? '0 : oq_tail_q + 1'b1;
			if (oq_pop)
				oq_head_q <= (oq_head_q == OQ_PW'(OQ_DEPTH - 1)) ? '0 : oq_head_q + 1'b1;
			if (oq_push && !oq_pop)
				oq_cnt_q <= oq_cnt_q + 1'b1;
			else if (oq_pop && !oq_push)
				oq_cnt_q <= oq_cnt_q - 1'b1;
		end
	end

	assign out_valid = (oq_cnt_q != '0);
	assign out_item  = oq_mem[oq_head_q];

endmodule

>>> sv/touch_contact_history_buffer.sv
// Touch contact history buffer: top level joining sequencer and datapath.
//
// Input channel (in_valid / in_stall) carries press, release and read items.
// Press and release items with an in-range contact_id append one history entry
// to the contact's ring and update the slot tables; they give no output item.
// A read item with an in-range slot resolves it to a contact and emits 16
// history entries on the output channel (out_valid / out_stall), last_of_run
// set on the sixteenth. An item is executed in the cycle after it is taken.
// A read then walks the ring one entry per cycle while the output queue has
// room, through the single read port of the history memory; each entry is
// registered from memory and then pushed into the output queue.
// A 3-entry output queue decouples the walk from the receiver: while out_stall
// is high the walk pauses once the queue, with the entry in flight, is full,
// and the next input item can be taken while queued entries still wait.
// Reset clears the sequencer, all per-contact counters and the slot tables.
// The ring memory itself is not cleared; per-contact fill counts make never
// written entries read as zero, so the block is ready right after reset.
module touch_contact_history_buffer
	import tchb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  contact_id,
	input  logic [3:0]  read_slot,
	input  logic [31:0] x_coord,
	input  logic [31:0] y_coord,
	input  logic [15:0] pressure,
	input  logic [15:0] touch_minor,
	input  logic [15:0] touch_major,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_number,
	output logic [1:0]  contact_status,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [15:0] out_pressure,
	output logic [15:0] out_minor,
	output logic [15:0] out_major,
	output logic        last_of_run
);

	tchb_cmd_t cmd;
	tchb_sts_t sts;
	out_item_t out_item;

	tchb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tchb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.contact_id  (contact_id),
		.read_slot   (read_slot),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.pressure    (pressure),
		.touch_minor (touch_minor),
		.touch_major (touch_major),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

	assign frame_number   = out_item.entry.frame;
	assign contact_status = out_item.entry.status;
	assign out_x          = out_item.entry.x;
	assign out_y          = out_item.entry.y;
	assign out_pressure   = out_item.entry.pressure;
	assign out_minor      = out_item.entry.minor;
	assign out_major      = out_item.entry.major;
	assign last_of_run    = out_item.last;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the touch contact history buffer.
`timescale 1ns / 100ps

module tb_top;
	import tchb_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         NO_CONTACT  = -1;
	localparam int         CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [7:0]  contact_id;
	logic [3:0]  read_slot;
	logic [31:0] x_coord;
	logic [31:0] y_coord;
	logic [15:0] pressure;
	logic [15:0] touch_minor;
	logic [15:0] touch_major;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  frame_number;
	logic [1:0]  contact_status;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [15:0] out_pressure;
	logic [15:0] out_minor;
	logic [15:0] out_major;
	logic        last_of_run;

	bit calm;
	int cycle_count = 0;

	// Mirror of the per-contact history rings and slot tables.
	class history_scoreboard;
		hist_entry_t ring [CONTACTS][RING_DEPTH];
		int          wr_ptr [CONTACTS];
		int          fill [CONTACTS];
		logic [7:0]  frame [CONTACTS];
		logic [1:0]  prior_st [CONTACTS];
		int          owner [CONTACTS];
		int          prev_owner [CONTACTS];
		out_item_t   pending [$];
		int          errors;

		function new();
			for (int c = 0; c < CONTACTS; c++) begin
				for (int i = 0; i < RING_DEPTH; i++)
					ring[c][i] = '0;
				wr_ptr[c] = 0;
				fill[c] = 0;
				frame[c] = '0;
				prior_st[c] = ST_RELEASE;
				owner[c] = NO_CONTACT;
				prev_owner[c] = NO_CONTACT;
			end
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		// first slot held by who (NO_CONTACT finds the first empty slot)
		function int find_slot(int who);
			for (int i = 0; i < CONTACTS; i++)
				if (owner[i] == who)
					return i;
			return NO_CONTACT;
		endfunction

		function void append(int c, logic [1:0] st, logic [31:0] x, logic [31:0] y,
				logic [15:0] p, logic [15:0] mn, logic [15:0] mj);
			hist_entry_t e;
			e.frame = frame[c];
			e.status = st;
			e.x = x;
			e.y = y;
			e.pressure = p;
			e.minor = mn;
			e.major = mj;
			ring[c][wr_ptr[c]] = e;
			frame[c] = frame[c] + 8'd1;
			prior_st[c] = st;
			if (fill[c] < READ_COUNT)
				fill[c]++;
			wr_ptr[c] = (wr_ptr[c] + 1) % RING_DEPTH;
		endfunction

		function void note_input(logic [1:0] op, logic [7:0] cid, logic [3:0] slot,
				logic [31:0] x, logic [31:0] y, logic [15:0] p, logic [15:0] mn,
				logic [15:0] mj);
			int c;
			int s;
			int rp;
			out_item_t e;
			c = int'(cid);
			if (op == OP_PRESS && c < CONTACTS) begin
				if (prior_st[c] == ST_RELEASE) begin
					append(c, ST_ENTER, x, y, p, mn, mj);
					if (find_slot(c) == NO_CONTACT) begin
						s = find_slot(NO_CONTACT);
						if (s != NO_CONTACT)
							owner[s] = c;
					end
				end else begin
					append(c, ST_MOVE, x, y, p, mn, mj);
				end
			end else if (op == OP_RELEASE && c < CONTACTS) begin
				append(c, ST_RELEASE, '1, '1, '0, '0, '0);
				s = find_slot(c);
				if (s != NO_CONTACT) begin
					prev_owner[s] = c;
					owner[s] = NO_CONTACT;
				end
			end else if (op == OP_READ && slot < CONTACTS) begin
				if (owner[slot] != NO_CONTACT)
					c = owner[slot];
				else if (prev_owner[slot] != NO_CONTACT)
					c = prev_owner[slot];
				else
					c = int'(slot);
				// newest window once full, else from the ring start
				rp = (fill[c] >= READ_COUNT) ? (wr_ptr[c] + RING_DEPTH - RD_OFF) % RING_DEPTH : 0;
				for (int k = 0; k < READ_COUNT; k++) begin
					e.entry = ring[c][rp];
					e.last = (k == READ_COUNT - 1);
					pending.push_back(e);
					rp = (rp + 1) % RING_DEPTH;
				end
			end
		endfunction

		task field_check(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got %0h, expected %0h", name, got, want));
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				report("output item with nothing expected");
				return;
			end
			want = pending.pop_front();
			field_check("frame_number", 32'(got.entry.frame), 32'(want.entry.frame));
			field_check("contact_status", 32'(got.entry.status), 32'(want.entry.status));
			field_check("out_x", got.entry.x, want.entry.x);
			field_check("out_y", got.entry.y, want.entry.y);
			field_check("out_pressure", 32'(got.entry.pressure), 32'(want.entry.pressure));
			field_check("out_minor", 32'(got.entry.minor), 32'(want.entry.minor));
			field_check("out_major", 32'(got.entry.major), 32'(want.entry.major));
			field_check("last_of_run", 32'(got.last), 32'(want.last));
		endtask
	endclass

	history_scoreboard sb;

	touch_contact_history_buffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.contact_id(contact_id),
		.read_slot(read_slot),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.pressure(pressure),
		.touch_minor(touch_minor),
		.touch_major(touch_major),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_number(frame_number),
		.contact_status(contact_status),
		.out_x(out_x),
		.out_y(out_y),
		.out_pressure(out_pressure),
		.out_minor(out_minor),
		.out_major(out_major),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input(opcode, contact_id, read_slot, x_coord, y_coord, pressure,
				touch_minor, touch_major);
		if (arst_n && out_valid && !out_stall)
			sb.check_result({frame_number, contact_status, out_x, out_y, out_pressure,
				out_minor, out_major, last_of_run});
	end

	always @(negedge clk) begin
		if (arst_n)
			out_stall <= !calm && ($urandom_range(99) < 20);
	end

	task automatic send(input logic [1:0] op, input logic [7:0] cid, input logic [3:0] slot,
			input logic [31:0] x, input logic [31:0] y, input logic [15:0] p,
			input logic [15:0] mn, input logic [15:0] mj);
		while (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		contact_id <= cid;
		read_slot <= slot;
		x_coord <= x;
		y_coord <= y;
		pressure <= p;
		touch_minor <= mn;
		touch_major <= mj;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_press(input logic [7:0] cid, input logic [31:0] x, input logic [31:0] y,
			input logic [15:0] p, input logic [15:0] mn, input logic [15:0] mj);
		send(OP_PRESS, cid, 4'($urandom), x, y, p, mn, mj);
	endtask

	task automatic send_release(input logic [7:0] cid);
		send(OP_RELEASE, cid, 4'($urandom), $urandom, $urandom, 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	task automatic send_read(input logic [3:0] slot);
		send(OP_READ, 8'($urandom), slot, $urandom, $urandom, 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	// focused: mostly press/release on one contact so its frame counter wraps
	task automatic send_random(input int hot, input bit focused);
		int unsigned r;
		logic [1:0] op;
		logic [7:0] cid;
		logic [3:0] slot;
		bit noise;
		r = $urandom_range(99);
		op = ($urandom_range(3) == 0) ? OP_RELEASE : OP_PRESS;
		cid = 8'($urandom_range(CONTACTS - 1));
		slot = 4'($urandom_range(CONTACTS - 1));
		noise = 1'b0;
		if (focused) begin
			if (r < 64) begin
				op = OP_PRESS;
				cid = 8'(hot);
			end else if (r < 80) begin
				op = OP_RELEASE;
				cid = 8'(hot);
			end else if (r >= 96) begin
				noise = 1'b1;
			end else if (r >= 88) begin
				op = OP_READ;
			end
		end else begin
			if (r < 45)
				op = OP_PRESS;
			else if (r < 62)
				op = OP_RELEASE;
			else if (r < 90)
				op = OP_READ;
			else
				noise = 1'b1;
		end
		if (noise) begin
			case ($urandom_range(2))
				0: op = OP_UNUSED;
				1: cid = 8'($urandom_range(255, CONTACTS));
				default: begin
					op = OP_READ;
					slot = 4'($urandom_range(15, CONTACTS));
				end
			endcase
		end
		send(op, cid, slot, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// hold the sender until every pending history entry has come out
	task automatic drain_outputs();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending.size() != 0);
	endtask

	initial begin
		int hot;
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		opcode = '0;
		contact_id = '0;
		read_slot = '0;
		x_coord = '0;
		y_coord = '0;
		pressure = '0;
		touch_minor = '0;
		touch_major = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty rings read back as zeros
		send_read(4'd0);
		send_read(4'd9);
		send_press(8'd0, '0, '0, '0, '0, '0);
		send_press(8'd0, '1, '1, '1, '1, '1);
		send_press(8'd9, 32'h8000_0001, 32'h7FFF_FFFE, 16'h8001, 16'h7FFE, 16'hA5A5);
		send_read(4'd1);
		send_release(8'd0);
		// release of a contact that holds no slot
		send_release(8'd5);
		// out of range contacts, unused opcode and slots are dropped
		send_press(8'd10, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
		send_press(8'd255, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
		send_release(8'd128);
		send(OP_UNUSED, 8'd1, 4'd1, '1, '1, '1, '1, '1);
		send_read(4'd10);
		send_read(4'd15);
		// slot 0 now falls back to its previous owner
		send_read(4'd0);
		send_press(8'd3, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
		send_read(4'd0);
		// no owner ever: slot number used as contact
		send_read(4'd5);
		send_press(8'd0, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
		send_read(4'd2);
		send_read(4'd8);
		drain_outputs();

		hot = $urandom_range(CONTACTS - 1);
		calm = 1'b1;
		for (int n = 0; n < 350; n++) begin
			if (n == 120)
				calm = 1'b0;
			send_random(hot, 1'b1);
		end
		drain_outputs();

		for (int n = 0; n < 90; n++)
			send_random(hot, 1'b0);
		drain_outputs();

		repeat (20) @(negedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
